[rtl/elk_pkg.sv]
package elk_pkg;

    // default configuration of the top level
    localparam int MAX_ITER_DEF  = 8;
    localparam int FRAC_BITS_DEF = 30;

    // fixed field widths
    localparam int K_W    = 32;
    localparam int KI_W   = 32;
    localparam int ITER_W = 6;
    localparam int TOL_W  = 16;

    // tolerance register reset value and its scale (units of 2^-30)
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd4;
    localparam int               TOL_SHIFT = 30;

    // pi in Q2.61 and one in Q.60
    localparam logic [63:0] PI_Q61  = 64'h6487ED5110B4611A;
    localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;

    // status of the shared add/subtract unit
    typedef struct packed {
        logic borrow;
        logic zero;
    } t_unit_flags;

endpackage

[rtl/elk_in_if.sv]
interface elk_in_if;
    import elk_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [K_W-1:0] k;

    modport source (output valid, output k, input ready);
    modport sink   (input valid, input k, output ready);
endinterface

[rtl/elk_out_if.sv]
interface elk_out_if;
    import elk_pkg::*;

    logic              valid;
    logic              ready;
    logic [KI_W-1:0]   k_integral;
    logic              saturated;
    logic [ITER_W-1:0] iterations;

    modport source (output valid, output k_integral, output saturated, output iterations,
                    input ready);
    modport sink   (input valid, input k_integral, input saturated, input iterations,
                    output ready);
endinterface

[rtl/elk_cfg_if.sv]
interface elk_cfg_if;
    import elk_pkg::*;

    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] tolerance;

    modport source (output valid, output tolerance, input ready);
    modport sink   (input valid, input tolerance, output ready);
endinterface

[rtl/elliptic_k_agm.sv]
// K(k) by the arithmetic-geometric mean. k is signed Q2.30, the result is unsigned Q6.26
// (all ones and saturated set when k^2 >= 1 or the quotient overflows). One transaction is
// in flight at a time: i_in.ready is high only while idle. Apart from the magnitude and square
// of k and 1 - k^2, all arithmetic runs through one shared add/subtract unit.
// The initial square root, the per-update multiply and square root, the 16-bit tolerance
// product and the final restoring division each produce one bit per cycle on that unit.
module elliptic_k_agm #(
    parameter int MAX_ITERATIONS = elk_pkg::MAX_ITER_DEF,
    parameter int FRACTION_BITS  = elk_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    elk_in_if.sink     i_in,
    elk_out_if.source  o_out,
    elk_cfg_if.sink    i_cfg
);
    import elk_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int AW    = F + 1;
    localparam int SW    = F + 2;
    localparam int LW    = 2 * F + 2;
    localparam int UW    = 2 * F + 4;
    localparam int RSHL  = (2 * F >= 60) ? 2 * F - 60 : 0;
    localparam int RSHR  = (2 * F < 60) ? 60 - 2 * F : 0;
    localparam int NSHL  = (F >= 35) ? F - 35 : 0;
    localparam int NSHR  = (F < 35) ? 35 - F : 0;
    localparam int NW    = 63 + NSHL;
    localparam int MAXC0 = (NW > AW) ? NW : AW;
    localparam int MAXC  = (MAXC0 > TOL_W) ? MAXC0 : TOL_W;
    localparam int CW    = $clog2(MAXC + 1);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_SQ   = 11'b000_0000_0010,
        S_PREP = 11'b000_0000_0100,
        S_SQRT = 11'b000_0000_1000,
        S_TOL  = 11'b000_0001_0000,
        S_ADD  = 11'b000_0010_0000,
        S_CMP  = 11'b000_0100_0000,
        S_SUM  = 11'b000_1000_0000,
        S_MUL  = 11'b001_0000_0000,
        S_DIV  = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    t_state              r_state;
    logic [TOL_W-1:0]    r_tol;
    logic [K_W-1:0]      r_k;
    logic [63:0]         r_ksq;
    logic [AW-1:0]       r_a;
    logic [AW-1:0]       r_g;
    logic [SW-1:0]       r_sum;
    logic [UW-1:0]       r_acc;
    logic [UW-1:0]       r_rem;
    logic [LW-1:0]       r_rad;
    logic [AW-1:0]       r_root;
    logic [TOL_W-1:0]    r_tsh;
    logic [NW-1:0]       r_num;
    logic [KI_W-1:0]     r_q;
    logic                r_ovf;
    logic [ITER_W-1:0]   r_iters;
    logic                r_stop;
    logic                r_init;
    logic [CW-1:0]       r_cnt;

    logic [UW-1:0]       u_x;
    logic [UW-1:0]       u_y;
    logic                u_sub;
    logic [UW-1:0]       u_res;
    t_unit_flags         u_flags;

    logic [K_W-1:0]      mag;
    logic [63:0]         diff;
    logic [AW-1:0]       n_root;
    logic                cnt_last;

    // shared arithmetic unit
    elk_unit #(.W(UW)) u_unit (
        .i_x     (u_x),
        .i_y     (u_y),
        .i_sub   (u_sub),
        .o_res   (u_res),
        .o_flags (u_flags)
    );

    // configuration register, always writable
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg.valid) begin
            r_tol <= i_cfg.tolerance;
        end
    end

    // operand selection for the shared unit
    always_comb begin
        u_x   = '0;
        u_y   = '0;
        u_sub = 1'b0;
        case (r_state)
            S_TOL: begin
                u_x = r_acc << 1;
                u_y = r_tsh[TOL_W-1] ? UW'(r_a) : '0;
            end
            S_ADD: begin
                u_x = UW'(r_g);
                u_y = r_acc >> TOL_SHIFT;
            end
            S_CMP: begin
                u_x   = UW'(r_a);
                u_y   = r_acc;
                u_sub = 1'b1;
            end
            S_SUM: begin
                u_x = UW'(r_a);
                u_y = UW'(r_g);
            end
            S_MUL: begin
                u_x = r_acc << 1;
                u_y = r_root[AW-1] ? UW'(r_a) : '0;
            end
            S_SQRT: begin
                u_x   = (r_rem << 2) | UW'(r_rad[LW-1:LW-2]);
                u_y   = (UW'(r_root) << 2) | UW'(1);
                u_sub = 1'b1;
            end
            S_DIV: begin
                u_x   = (r_rem << 1) | UW'(r_num[NW-1]);
                u_y   = UW'(r_sum);
                u_sub = 1'b1;
            end
            default: begin
                u_x = '0;
            end
        endcase
    end

    // magnitude of k, radicand of the first root, next root digit
    assign mag      = r_k[K_W-1] ? (~r_k + K_W'(1)) : r_k;
    assign diff     = ONE_Q60 - r_ksq;
    assign n_root   = {r_root[AW-2:0], ~u_flags.borrow};
    assign cnt_last = (r_cnt == '0);

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_k     <= i_in.k;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_ksq   <= 64'(mag) * 64'(mag);
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_iters <= '0;
                    if (r_ksq[63:60] != 4'd0) begin
                        r_ovf   <= 1'b1;
                        r_q     <= '1;
                        r_state <= S_OUT;
                    end else begin
                        r_ovf   <= 1'b0;
                        r_rad   <= LW'(diff >> RSHR) << RSHL;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_init  <= 1'b1;
                        r_cnt   <= CW'(AW - 1);
                        r_state <= S_SQRT;
                    end
                end
                // one result bit per cycle
                S_SQRT: begin
                    r_rem  <= u_flags.borrow ? u_x : u_res;
                    r_root <= n_root;
                    r_rad  <= r_rad << 2;
                    r_cnt  <= r_cnt - CW'(1);
                    if (cnt_last) begin
                        r_g <= n_root;
                        if (r_init) begin
                            r_a <= {1'b1, {F{1'b0}}};
                        end else begin
                            r_a     <= r_sum[SW-1:1];
                            r_iters <= r_iters + ITER_W'(1);
                        end
                        r_init  <= 1'b0;
                        r_acc   <= '0;
                        r_tsh   <= r_tol;
                        r_cnt   <= CW'(TOL_W - 1);
                        r_state <= S_TOL;
                    end
                end
                // a times tolerance, msb first
                S_TOL: begin
                    r_acc <= u_res;
                    r_tsh <= r_tsh << 1;
                    r_cnt <= r_cnt - CW'(1);
                    if (cnt_last) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_acc   <= u_res;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_stop  <= u_flags.borrow | u_flags.zero
                               | (r_iters >= ITER_W'(MAX_ITERATIONS));
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum <= u_res[SW-1:0];
                    if (r_stop) begin
                        r_rem   <= '0;
                        r_num   <= NW'(PI_Q61 >> NSHR) << NSHL;
                        r_q     <= '0;
                        r_ovf   <= u_flags.zero;
                        r_cnt   <= CW'(NW - 1);
                        r_state <= S_DIV;
                    end else begin
                        r_acc   <= '0;
                        r_root  <= r_g;
                        r_cnt   <= CW'(AW - 1);
                        r_state <= S_MUL;
                    end
                end
                // a times g, shift and add
                S_MUL: begin
                    r_acc  <= u_res;
                    r_root <= r_root << 1;
                    r_cnt  <= r_cnt - CW'(1);
                    if (cnt_last) begin
                        r_rad   <= u_res[LW-1:0];
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= CW'(AW - 1);
                        r_state <= S_SQRT;
                    end
                end
                // restoring division of pi by a + g
                S_DIV: begin
                    r_rem <= u_flags.borrow ? u_x : u_res;
                    r_q   <= {r_q[KI_W-2:0], ~u_flags.borrow};
                    r_ovf <= r_ovf | r_q[KI_W-1];
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - CW'(1);
                    if (cnt_last) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // handshake and result
    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = (r_state == S_OUT);
    assign o_out.k_integral = r_ovf ? '1 : r_q;
    assign o_out.saturated  = r_ovf;
    assign o_out.iterations = r_iters;

    // a result never waits while a new item is taken
    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while result pending");

    // an accepted item starts the squaring step
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_SQ))
        else $error("accepted item did not start");

    // the update count never passes the cap
    a_iter_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.iterations <= ITER_W'(MAX_ITERATIONS)))
        else $error("iteration count beyond cap");

    // a saturated result reads all ones
    a_sat_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |-> (o_out.k_integral == '1))
        else $error("saturated result not all ones");
endmodule

[rtl/elk_unit.sv]
module elk_unit #(
    parameter int W = 64
) (
    input  logic [W-1:0]         i_x,
    input  logic [W-1:0]         i_y,
    input  logic                 i_sub,
    output logic [W-1:0]         o_res,
    output elk_pkg::t_unit_flags o_flags
);
    import elk_pkg::*;

    logic [W:0] full;

    // one adder/subtractor, carry out of a subtract is the borrow
    assign full           = i_sub ? ({1'b0, i_x} - {1'b0, i_y}) : ({1'b0, i_x} + {1'b0, i_y});
    assign o_res          = full[W-1:0];
    assign o_flags.borrow = i_sub & full[W];
    assign o_flags.zero   = (full[W-1:0] == '0);
endmodule
